// ===== rtl/htsed_pkg.sv =====
// Shared constants, types and entity tables for the HTML tag strip and entity decode unit.
package htsed_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntW       = 3;
  localparam int unsigned ProgW      = 4;

  typedef logic [ByteW-1:0]            byte_t;
  typedef logic [ProgW-1:0]            prog_t;
  typedef logic [CntW-1:0]             cnt_t;
  typedef logic [ByteW*MaxResults-1:0] text_t;

  // Characters of interest
  localparam byte_t CHR_NUL  = 8'h00;
  localparam byte_t CHR_LT   = 8'h3C;
  localparam byte_t CHR_GT   = 8'h3E;
  localparam byte_t CHR_AMP  = 8'h26;
  localparam byte_t CHR_SEMI = 8'h3B;
  localparam byte_t CHR_QUOT = 8'h22;
  localparam byte_t CHR_A    = 8'h61;
  localparam byte_t CHR_G    = 8'h67;
  localparam byte_t CHR_L    = 8'h6C;
  localparam byte_t CHR_M    = 8'h6D;
  localparam byte_t CHR_O    = 8'h6F;
  localparam byte_t CHR_P    = 8'h70;
  localparam byte_t CHR_Q    = 8'h71;
  localparam byte_t CHR_T    = 8'h74;
  localparam byte_t CHR_U    = 8'h75;

  // Pending entity prefix codes
  localparam prog_t P_NONE     = 4'd0;
  localparam prog_t P_AMP      = 4'd1;   // "&"
  localparam prog_t P_AMP_L    = 4'd2;   // "&l"
  localparam prog_t P_AMP_LT   = 4'd3;   // "&lt"
  localparam prog_t P_AMP_G    = 4'd4;   // "&g"
  localparam prog_t P_AMP_GT   = 4'd5;   // "&gt"
  localparam prog_t P_AMP_A    = 4'd6;   // "&a"
  localparam prog_t P_AMP_AM   = 4'd7;   // "&am"
  localparam prog_t P_AMP_AMP  = 4'd8;   // "&amp"
  localparam prog_t P_AMP_Q    = 4'd9;   // "&q"
  localparam prog_t P_AMP_QU   = 4'd10;  // "&qu"
  localparam prog_t P_AMP_QUO  = 4'd11;  // "&quo"
  localparam prog_t P_AMP_QUOT = 4'd12;  // "&quot"

  // Length of the literal text of a pending prefix
  function automatic cnt_t pend_len(prog_t c);
    cnt_t len;
    unique case (c)
      P_AMP:                                   len = 3'd1;
      P_AMP_L, P_AMP_G, P_AMP_A, P_AMP_Q:      len = 3'd2;
      P_AMP_LT, P_AMP_GT, P_AMP_AM, P_AMP_QU:  len = 3'd3;
      P_AMP_AMP, P_AMP_QUO:                    len = 3'd4;
      P_AMP_QUOT:                              len = 3'd5;
      default:                                 len = 3'd0;
    endcase
    return len;
  endfunction

  // Literal text of a pending prefix, first byte in the lowest bits
  function automatic text_t pend_text(prog_t c);
    text_t txt;
    unique case (c)
      P_AMP:      txt = {40'h0, CHR_AMP};
      P_AMP_L:    txt = {32'h0, CHR_L, CHR_AMP};
      P_AMP_LT:   txt = {24'h0, CHR_T, CHR_L, CHR_AMP};
      P_AMP_G:    txt = {32'h0, CHR_G, CHR_AMP};
      P_AMP_GT:   txt = {24'h0, CHR_T, CHR_G, CHR_AMP};
      P_AMP_A:    txt = {32'h0, CHR_A, CHR_AMP};
      P_AMP_AM:   txt = {24'h0, CHR_M, CHR_A, CHR_AMP};
      P_AMP_AMP:  txt = {16'h0, CHR_P, CHR_M, CHR_A, CHR_AMP};
      P_AMP_Q:    txt = {32'h0, CHR_Q, CHR_AMP};
      P_AMP_QU:   txt = {24'h0, CHR_U, CHR_Q, CHR_AMP};
      P_AMP_QUO:  txt = {16'h0, CHR_O, CHR_U, CHR_Q, CHR_AMP};
      P_AMP_QUOT: txt = {8'h0, CHR_T, CHR_O, CHR_U, CHR_Q, CHR_AMP};
      default:    txt = '0;
    endcase
    return txt;
  endfunction

endpackage

// ===== rtl/html_tag_strip_entity_decode_unit.sv =====
// HTML tag stripper with entity decoding: streaming top level.
//
// Takes HTML text one byte per transfer and emits plain text one byte per
// transfer. Tags ('<' ... '>') are removed, and &lt; &gt; &amp; &quot; are
// decoded. While out_tready is high, a byte yielding at most one output byte
// never holds the input, so plain text moves at one byte per clock. A byte
// yielding more (a broken entity prefix flushed literally, up to six bytes)
// holds the input while the result buffer drains one byte per ready cycle;
// the next input is taken in the cycle its last byte leaves. out_tlast marks
// the last output byte caused by one input byte; out_tuser marks the last
// output byte of the stream. State returns to reset after an in_tlast input.
module html_tag_strip_entity_decode_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // [0] stream_last
);

  // Parser state
  logic                  inside_tag_r, inside_tag_nxt;
  htsed_pkg::prog_t      prog_r, prog_nxt;

  // Result buffer: bytes shift toward slot 0 as they are transferred
  htsed_pkg::byte_t      buf_r   [htsed_pkg::MaxResults];
  htsed_pkg::byte_t      buf_nxt [htsed_pkg::MaxResults];
  htsed_pkg::cnt_t       cnt_r, cnt_nxt;
  logic                  strm_r, strm_nxt;

  logic                  in_xfer, out_xfer;

  // Prefix matching
  htsed_pkg::prog_t      prog_cur;
  htsed_pkg::prog_t      adv_prog;
  logic                  adv_hit;
  logic                  ent_hit;
  htsed_pkg::byte_t      ent_val;

  // Result assembly: literal prefix text followed by an optional extra byte
  htsed_pkg::prog_t      flush_code;
  logic                  has_x;
  htsed_pkg::byte_t      x_byte;
  logic                  fresh;
  htsed_pkg::cnt_t       flush_len;
  htsed_pkg::text_t      flush_txt;

  assign in_tready  = (cnt_r == '0) || ((cnt_r == htsed_pkg::cnt_t'(1)) && out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (cnt_r == htsed_pkg::cnt_t'(1));
  assign out_tuser  = (cnt_r == htsed_pkg::cnt_t'(1)) && strm_r;

  // Next prefix or completed entity for the pending prefix and current byte
  always_comb begin
    prog_cur = (prog_r > htsed_pkg::P_AMP_QUOT) ? htsed_pkg::P_NONE : prog_r;
    adv_prog = htsed_pkg::P_NONE;
    adv_hit  = 1'b0;
    ent_hit  = 1'b0;
    ent_val  = htsed_pkg::CHR_NUL;
    unique case (prog_cur)
      htsed_pkg::P_AMP: begin
        if (in_tdata == htsed_pkg::CHR_L) begin
          adv_hit = 1'b1; adv_prog = htsed_pkg::P_AMP_L;
        end else if (in_tdata == htsed_pkg::CHR_G) begin
          adv_hit = 1'b1; adv_prog = htsed_pkg::P_AMP_G;
        end else if (in_tdata == htsed_pkg::CHR_A) begin
          adv_hit = 1'b1; adv_prog = htsed_pkg::P_AMP_A;
        end else if (in_tdata == htsed_pkg::CHR_Q) begin
          adv_hit = 1'b1; adv_prog = htsed_pkg::P_AMP_Q;
        end
      end
      htsed_pkg::P_AMP_L: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_T);
        adv_prog = htsed_pkg::P_AMP_LT;
      end
      htsed_pkg::P_AMP_LT: begin
        ent_hit = (in_tdata == htsed_pkg::CHR_SEMI);
        ent_val = htsed_pkg::CHR_LT;
      end
      htsed_pkg::P_AMP_G: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_T);
        adv_prog = htsed_pkg::P_AMP_GT;
      end
      htsed_pkg::P_AMP_GT: begin
        ent_hit = (in_tdata == htsed_pkg::CHR_SEMI);
        ent_val = htsed_pkg::CHR_GT;
      end
      htsed_pkg::P_AMP_A: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_M);
        adv_prog = htsed_pkg::P_AMP_AM;
      end
      htsed_pkg::P_AMP_AM: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_P);
        adv_prog = htsed_pkg::P_AMP_AMP;
      end
      htsed_pkg::P_AMP_AMP: begin
        ent_hit = (in_tdata == htsed_pkg::CHR_SEMI);
        ent_val = htsed_pkg::CHR_AMP;
      end
      htsed_pkg::P_AMP_Q: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_U);
        adv_prog = htsed_pkg::P_AMP_QU;
      end
      htsed_pkg::P_AMP_QU: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_O);
        adv_prog = htsed_pkg::P_AMP_QUO;
      end
      htsed_pkg::P_AMP_QUO: begin
        adv_hit  = (in_tdata == htsed_pkg::CHR_T);
        adv_prog = htsed_pkg::P_AMP_QUOT;
      end
      htsed_pkg::P_AMP_QUOT: begin
        ent_hit = (in_tdata == htsed_pkg::CHR_SEMI);
        ent_val = htsed_pkg::CHR_QUOT;
      end
      default: begin
        adv_hit = 1'b0;
      end
    endcase
  end

  // Per-byte decision: state update, flushed prefix and extra byte
  always_comb begin
    flush_code     = htsed_pkg::P_NONE;
    has_x          = 1'b0;
    x_byte         = in_tdata;
    fresh          = 1'b0;
    inside_tag_nxt = inside_tag_r;
    prog_nxt       = prog_cur;

    if (in_tdata != htsed_pkg::CHR_NUL) begin
      if (prog_cur != htsed_pkg::P_NONE) begin
        if (ent_hit) begin
          has_x    = 1'b1;
          x_byte   = ent_val;
          prog_nxt = htsed_pkg::P_NONE;
        end else if (adv_hit) begin
          prog_nxt = adv_prog;
        end else begin
          // broken prefix: emit it literally, then treat the byte afresh
          flush_code = prog_cur;
          prog_nxt   = htsed_pkg::P_NONE;
          fresh      = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
    end

    if (fresh) begin
      if (in_tdata == htsed_pkg::CHR_LT) begin
        inside_tag_nxt = 1'b1;
      end else if (in_tdata == htsed_pkg::CHR_GT) begin
        inside_tag_nxt = 1'b0;
      end else if (inside_tag_r) begin
        has_x = 1'b0;
      end else if (in_tdata == htsed_pkg::CHR_AMP) begin
        prog_nxt = htsed_pkg::P_AMP;
      end else begin
        has_x = 1'b1;
      end
    end

    // end of stream: flush whatever prefix is still pending
    if (in_tlast) begin
      if (prog_nxt != htsed_pkg::P_NONE) begin
        if (flush_code == htsed_pkg::P_NONE) begin
          flush_code = prog_nxt;
        end else begin
          // only a fresh '&' can be pending after a broken prefix
          has_x  = 1'b1;
          x_byte = htsed_pkg::CHR_AMP;
        end
      end
      prog_nxt       = htsed_pkg::P_NONE;
      inside_tag_nxt = 1'b0;
    end

    flush_len = htsed_pkg::pend_len(flush_code);
    flush_txt = htsed_pkg::pend_text(flush_code);
  end

  // Result buffer load and drain
  always_comb begin
    cnt_nxt  = cnt_r;
    strm_nxt = strm_r;
    for (int i = 0; i < htsed_pkg::MaxResults; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (in_xfer) begin
      cnt_nxt  = flush_len + htsed_pkg::cnt_t'(has_x);
      strm_nxt = in_tlast;
      for (int i = 0; i < htsed_pkg::MaxResults; i++) begin
        if (htsed_pkg::cnt_t'(i) < flush_len) begin
          buf_nxt[i] = flush_txt[i*htsed_pkg::ByteW +: htsed_pkg::ByteW];
        end else begin
          buf_nxt[i] = x_byte;
        end
      end
    end else if (out_xfer) begin
      cnt_nxt = cnt_r - htsed_pkg::cnt_t'(1);
      for (int i = 0; i < htsed_pkg::MaxResults - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_tag_r <= 1'b0;
      prog_r       <= htsed_pkg::P_NONE;
      cnt_r        <= '0;
      strm_r       <= 1'b0;
    end else begin
      if (in_xfer) begin
        inside_tag_r <= inside_tag_nxt;
        prog_r       <= prog_nxt;
      end
      cnt_r  <= cnt_nxt;
      strm_r <= strm_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < htsed_pkg::MaxResults; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  // Buffer never holds more than one input's worth of results
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= htsed_pkg::cnt_t'(htsed_pkg::MaxResults))
    else $error("result count out of range");

  // Prefix code stays within the defined set
  a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= htsed_pkg::P_AMP_QUOT)
    else $error("entity prefix code out of range");

  // A new byte is taken only when the buffer is empty or draining its last entry
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (cnt_r == '0) || ((cnt_r == htsed_pkg::cnt_t'(1)) && out_xfer))
    else $error("input accepted over pending results");

  // End of stream leaves the parser in its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> (!inside_tag_r && (prog_r == htsed_pkg::P_NONE)))
    else $error("state not cleared after final byte");

  // Stream end only flags the last byte of a run
  a_strm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tuser |-> out_tlast && out_tvalid)
    else $error("stream end flag off the last result");

endmodule

// ===== dv/tb_html_tag_strip_entity_decode_unit.sv =====
// Testbench for the HTML tag strip and entity decode unit: directed and random streams against a predictor.
module tb_html_tag_strip_entity_decode_unit;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandItems = 480;

  // One input transfer waiting to be driven
  typedef struct {
    htsed_pkg::byte_t data;
    bit               last;
    int               phase;
  } html_byte_t;

  // One expected output transfer
  typedef struct {
    htsed_pkg::byte_t text;
    bit               run_last;
    bit               stream_last;
  } plain_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;    // [7:0] in_byte
  logic       in_tlast = 1'b0;     // in_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;           // run_last
  logic       out_tuser;           // [0] stream_last

  html_byte_t       html_src_q[$];
  plain_byte_t      plain_text_q[$];
  htsed_pkg::byte_t stream_buf[$];

  // Decoder state as the testbench sees it
  bit               in_tag;
  htsed_pkg::byte_t held_q[$];

  int unsigned send_idle_pct[3] = '{21, 64, 0};
  int unsigned recv_stall_pct[3] = '{64, 21, 0};
  int          cur_phase = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  string ent_txt[4] = '{"&lt;", "&gt;", "&amp;", "&quot;"};
  htsed_pkg::byte_t ent_val[4] = '{htsed_pkg::CHR_LT, htsed_pkg::CHR_GT,
                                   htsed_pkg::CHR_AMP, htsed_pkg::CHR_QUOT};

  html_tag_strip_entity_decode_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    err_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // Byte handled with nothing pending
  task automatic strip_fresh(htsed_pkg::byte_t b, ref htsed_pkg::byte_t res[$]);
    if (b == htsed_pkg::CHR_LT) begin
      in_tag = 1'b1;
    end else if (b == htsed_pkg::CHR_GT) begin
      in_tag = 1'b0;
    end else if (in_tag) begin
      // dropped inside a tag
    end else if (b == htsed_pkg::CHR_AMP) begin
      held_q = '{htsed_pkg::CHR_AMP};
    end else begin
      res.push_back(b);
    end
  endtask

  // Works out the output transfers caused by one input transfer
  task automatic decode_html_byte(htsed_pkg::byte_t b, bit last);
    htsed_pkg::byte_t res[$];
    htsed_pkg::byte_t cand[$];
    plain_byte_t      r;
    string            s;
    int               full;
    bit               part;
    bit               ok;
    full = -1;
    part = 1'b0;
    if (b != htsed_pkg::CHR_NUL) begin
      if (held_q.size() != 0) begin
        cand = held_q;
        cand.push_back(b);
        for (int e = 0; e < 4; e++) begin
          s = ent_txt[e];
          if (cand.size() <= s.len()) begin
            ok = 1'b1;
            for (int j = 0; j < cand.size(); j++)
              if (cand[j] != htsed_pkg::byte_t'(s[j])) ok = 1'b0;
            if (ok && cand.size() == s.len()) full = e;
            else if (ok) part = 1'b1;
          end
        end
        if (full >= 0) begin
          res.push_back(ent_val[full]);
          held_q.delete();
        end else if (part) begin
          held_q = cand;
        end else begin
          // broken prefix goes out literally, then the byte starts over
          foreach (held_q[i]) res.push_back(held_q[i]);
          held_q.delete();
          strip_fresh(b, res);
        end
      end else begin
        strip_fresh(b, res);
      end
    end
    if (last) begin
      foreach (held_q[i]) res.push_back(held_q[i]);
      held_q.delete();
      in_tag = 1'b0;
    end
    foreach (res[i]) begin
      r.text        = res[i];
      r.run_last    = (i == res.size() - 1);
      r.stream_last = last && r.run_last;
      plain_text_q.push_back(r);
    end
  endtask

  task automatic push_item(htsed_pkg::byte_t b, bit last, int ph);
    html_byte_t it;
    it.data  = b;
    it.last  = last;
    it.phase = ph;
    html_src_q.push_back(it);
  endtask

  task automatic push_text(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      push_item(htsed_pkg::byte_t'(s[i]), last_at_end && (i == s.len() - 1), 0);
  endtask

  // Appends the first n characters of s to the stream under construction
  task automatic add_text(string s, int n);
    for (int i = 0; i < n; i++) stream_buf.push_back(htsed_pkg::byte_t'(s[i]));
  endtask

  // Byte likely to continue, end or restart an entity
  function automatic htsed_pkg::byte_t entity_probe();
    htsed_pkg::byte_t pool[14] = '{htsed_pkg::CHR_AMP, htsed_pkg::CHR_LT,
                                   htsed_pkg::CHR_GT, htsed_pkg::CHR_SEMI,
                                   htsed_pkg::CHR_L, htsed_pkg::CHR_T,
                                   htsed_pkg::CHR_G, htsed_pkg::CHR_A,
                                   htsed_pkg::CHR_M, htsed_pkg::CHR_P,
                                   htsed_pkg::CHR_Q, htsed_pkg::CHR_U,
                                   htsed_pkg::CHR_O, 8'h20};
    if ($urandom_range(4, 0) == 0) return htsed_pkg::byte_t'($urandom_range(255, 1));
    return pool[$urandom_range(13, 0)];
  endfunction

  // Input driver
  always @(posedge clk) begin : drive_proc
    html_byte_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (html_src_q.size() != 0 &&
          $urandom_range(99, 0) >= send_idle_pct[cur_phase]) begin
        it = html_src_q.pop_front();
        cur_phase <= it.phase;
        in_tvalid <= 1'b1;
        in_tdata  <= it.data;
        in_tlast  <= it.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99, 0) >= recv_stall_pct[cur_phase]);
  end

  // Monitor: predict on input transfers first, then check output transfers
  always @(posedge clk) begin : check_proc
    plain_byte_t exp_b;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_html_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (plain_text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", out_tdata));
        end else begin
          exp_b = plain_text_q.pop_front();
          if (out_tdata !== exp_b.text)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_tdata, exp_b.text));
          if (out_tlast !== exp_b.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      out_tlast, exp_b.run_last));
          if (out_tuser !== exp_b.stream_last)
            report_mismatch($sformatf("stream_last %b, expected %b",
                                      out_tuser, exp_b.stream_last));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TIMEOUT: no transfer for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim_proc
    int    n_rand;
    int    pick;
    int    ph;
    int    e;
    string ent;
    n_rand = 0;

    // Directed: byte extremes, stray close, a tag, two entities,
    // a broken five-byte prefix and a stream cut off mid-entity
    push_item(8'h01, 1'b0, 0);
    push_item(8'hFF, 1'b0, 0);
    push_text(">< x>&lt;&quot;&quotx", 1'b0);
    push_text("&a", 1'b1);

    // Random streams, mostly well-formed markup with random content
    while (n_rand < RandItems) begin
      ph = (n_rand < RandItems / 3) ? 0 : (n_rand < 2 * RandItems / 3) ? 1 : 2;
      stream_buf.delete();
      repeat ($urandom_range(12, 1)) begin
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
          stream_buf.push_back(htsed_pkg::byte_t'($urandom_range(126, 32)));
        end else if (pick < 40) begin
          stream_buf.push_back(htsed_pkg::byte_t'($urandom_range(255, 1)));
        end else if (pick < 55) begin
          stream_buf.push_back(htsed_pkg::CHR_LT);
          repeat ($urandom_range(6, 0))
            stream_buf.push_back(($urandom_range(3, 0) == 0) ?
                                 htsed_pkg::byte_t'($urandom_range(255, 1)) :
                                 entity_probe());
          stream_buf.push_back(htsed_pkg::CHR_GT);
        end else if (pick < 75) begin
          ent = ent_txt[$urandom_range(3, 0)];
          add_text(ent, ent.len());
        end else if (pick < 92) begin
          ent = ent_txt[$urandom_range(3, 0)];
          add_text(ent, $urandom_range(ent.len() - 1, 1));
          stream_buf.push_back(entity_probe());
        end else begin
          stream_buf.push_back(htsed_pkg::CHR_GT);
        end
      end
      // some streams end in the middle of an entity
      if ($urandom_range(3, 0) == 0) begin
        e = $urandom_range(3, 0);
        ent = ent_txt[e];
        add_text(ent, $urandom_range(ent.len() - 1, 1));
      end
      foreach (stream_buf[i])
        push_item(stream_buf[i], i == stream_buf.size() - 1, ph);
      n_rand += stream_buf.size();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (html_src_q.size() != 0 || in_tvalid || plain_text_q.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
